// ----- design/hsl2rgb_pkg.sv -----
// Shared types, constants and helpers of the HSL to RGB converter.
// Used by every module in this folder; depends on nothing else.
package hsl2rgb_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned NumStg  = 6;
  localparam int unsigned QW      = 19;
  localparam int unsigned VW      = 20;
  localparam int unsigned MW      = 19;
  localparam int unsigned PW      = VW + MW;

  localparam logic [17:0] ThirdQ     = 18'd87381;
  localparam logic [17:0] NegThirdQ  = 18'd174763;
  localparam logic [17:0] SixthLt    = 18'd43691;
  localparam logic [17:0] HalfLt     = 18'd131072;
  localparam logic [17:0] TwoThirdLt = 18'd174763;
  localparam logic [QW-1:0] QHalf    = 19'd131072;
  localparam logic [20:0] FourOne    = 21'd1048576;
  localparam logic [39:0] RndRamp    = 40'd131072;
  localparam logic [38:0] RndLs      = 39'd131072;
  localparam logic [29:0] RndByte    = 30'd131072;

  typedef enum logic [1:0] {
    RG_RISE,
    RG_HIGH,
    RG_FALL,
    RG_LOW
  } region_e;

  typedef struct packed {
    region_e         region;
    logic [MW-1:0]   mult;
  } chan_t;

  typedef struct packed {
    logic            zero;
    logic [QW-1:0]   l;
    logic [VW-1:0]   p;
    logic [VW-1:0]   q;
    logic [VW-1:0]   d;
  } shape_t;

  function automatic logic [QW-1:0] frac_to_q(input logic [15:0] x);
    logic [QW-1:0] base;
    logic [QW-1:0] b;
    logic [2:0]    k;
    base = {1'b0, x, 2'b00};
    b    = base + 19'd32767;
    k    = 3'd0;
    if (b >= 19'd65535)  k = 3'd1;
    if (b >= 19'd131070) k = 3'd2;
    if (b >= 19'd196605) k = 3'd3;
    if (b >= 19'd262140) k = 3'd4;
    return base + {16'd0, k};
  endfunction

endpackage

// ----- design/hsl2rgb_prep.sv -----
// Front stages: fixed-point conversion, l*s product, q/p/d and hue ramp positions.
// Depends on hsl2rgb_pkg.
module hsl2rgb_prep (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [15:0]                           hue_i,
  input  logic [15:0]                           saturation_i,
  input  logic [15:0]                           lightness_i,
  output hsl2rgb_pkg::shape_t                   shape_o,
  output hsl2rgb_pkg::chan_t [hsl2rgb_pkg::NumChan-1:0] chan_o
);
  import hsl2rgb_pkg::*;

  logic            s1_zero_q;
  logic [QW-1:0]   s1_s_q, s1_l_q;
  logic [17:0]     s1_t_q [NumChan];

  logic            s2_zero_q;
  logic [QW-1:0]   s2_s_q, s2_l_q;
  logic [2*QW-1:0] s2_prod_q;
  chan_t [NumChan-1:0] s2_chan_q, s2_chan_d;

  shape_t              s3_shape_q, s3_shape_d;
  chan_t [NumChan-1:0] s3_chan_q;

  logic [17:0] h;
  logic [38:0] ls_sum;
  logic [QW-1:0] ls;
  logic [VW-1:0] l2, q_v, p_v;
  logic [20:0] six_t [NumChan];
  logic [20:0] fall_m [NumChan];

  assign h = {hue_i, 2'b00};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_zero_q <= (saturation_i == 16'd0);
      s1_s_q    <= frac_to_q(saturation_i);
      s1_l_q    <= frac_to_q(lightness_i);
      s1_t_q[0] <= h + ThirdQ;
      s1_t_q[1] <= h;
      s1_t_q[2] <= h + NegThirdQ;
    end
  end

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      six_t[i]  = {3'd0, s1_t_q[i]} * 21'd6;
      fall_m[i] = FourOne - six_t[i];
      priority if (s1_t_q[i] < SixthLt) begin
        s2_chan_d[i].region = RG_RISE;
        s2_chan_d[i].mult   = six_t[i][MW-1:0];
      end else if (s1_t_q[i] < HalfLt) begin
        s2_chan_d[i].region = RG_HIGH;
        s2_chan_d[i].mult   = '0;
      end else if (s1_t_q[i] < TwoThirdLt) begin
        s2_chan_d[i].region = RG_FALL;
        s2_chan_d[i].mult   = fall_m[i][MW-1:0];
      end else begin
        s2_chan_d[i].region = RG_LOW;
        s2_chan_d[i].mult   = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_zero_q <= s1_zero_q;
      s2_s_q    <= s1_s_q;
      s2_l_q    <= s1_l_q;
      s2_prod_q <= s1_l_q * s1_s_q;
      s2_chan_q <= s2_chan_d;
    end
  end

  always_comb begin
    ls_sum = {1'b0, s2_prod_q} + RndLs;
    ls     = ls_sum[36:18];
    l2     = {s2_l_q, 1'b0};
    if (s2_l_q < QHalf) begin
      q_v = {1'b0, s2_l_q} + {1'b0, ls};
    end else begin
      q_v = {1'b0, s2_l_q} + {1'b0, s2_s_q} - {1'b0, ls};
    end
    p_v = (l2 >= q_v) ? l2 - q_v : '0;
    s3_shape_d.zero = s2_zero_q;
    s3_shape_d.l    = s2_l_q;
    s3_shape_d.q    = q_v;
    s3_shape_d.p    = p_v;
    s3_shape_d.d    = (q_v >= p_v) ? q_v - p_v : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_shape_q <= s3_shape_d;
      s3_chan_q  <= s2_chan_q;
    end
  end

  assign shape_o = s3_shape_q;
  assign chan_o  = s3_chan_q;

endmodule

// ----- design/hsl2rgb_ramp.sv -----
// Back stages of one color channel: ramp product, level select, byte scaling.
// Depends on hsl2rgb_pkg.
module hsl2rgb_ramp (
  input  logic                clk_i,
  input  logic                en_i,
  input  hsl2rgb_pkg::shape_t shape_i,
  input  hsl2rgb_pkg::chan_t  chan_i,
  output logic [7:0]          byte_o
);
  import hsl2rgb_pkg::*;

  shape_t        s4_shape_q;
  region_e       s4_region_q;
  logic [PW-1:0] s4_prod_q;

  logic [21:0]   s5_v_q, s5_v_d;
  logic [7:0]    s6_byte_q, s6_byte_d;

  logic [39:0]   rnd_sum;
  logic [21:0]   step;
  logic [29:0]   scaled;
  logic [11:0]   r;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_shape_q  <= shape_i;
      s4_region_q <= chan_i.region;
      s4_prod_q   <= shape_i.d * chan_i.mult;
    end
  end

  always_comb begin
    rnd_sum = {1'b0, s4_prod_q} + RndRamp;
    step    = rnd_sum[39:18];
    if (s4_shape_q.zero) begin
      s5_v_d = {3'd0, s4_shape_q.l};
    end else begin
      unique case (s4_region_q)
        RG_RISE, RG_FALL: s5_v_d = {2'd0, s4_shape_q.p} + step;
        RG_HIGH:          s5_v_d = {2'd0, s4_shape_q.q};
        RG_LOW:           s5_v_d = {2'd0, s4_shape_q.p};
        default:          s5_v_d = {2'd0, s4_shape_q.p};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_v_q <= s5_v_d;
    end
  end

  always_comb begin
    scaled    = {s5_v_q, 8'd0} - {8'd0, s5_v_q} + RndByte;
    r         = scaled[29:18];
    s6_byte_d = (r > 12'd255) ? 8'd255 : r[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_byte_q <= s6_byte_d;
    end
  end

  assign byte_o = s6_byte_q;

endmodule

// ----- design/hsl_to_rgb_converter.sv -----
// Top level of the HSL to RGB converter: handshake, valid chain, three channels.
// Depends on hsl2rgb_pkg, hsl2rgb_prep and hsl2rgb_ramp.
//
// Usage:
//   Input channel valid_i/ready_o carries one pixel word: hue_i (fraction of a
//   turn, /65536), saturation_i and lightness_i (/65535). Output channel
//   valid_o/ready_i carries red_o, green_o, blue_o, rounded and clamped.
//   valid_o rises when an accepted word reaches the last stage. Throughput
//   is one word per cycle unless the receiver stalls: the six register
//   stages (conversion, l*s product, q/p shaping, ramp product, level select,
//   byte scaling) all advance together.
//   When the receiver stalls with a word on the output, the whole pipeline
//   holds and ready_o drops; nothing is lost or repeated. Bubbles inside the
//   pipeline are not squeezed out: only the output stage can stall it, so
//   ready_o stays high while the output register is empty.
//   Reset clears all stage valid bits; the first word can be taken right after
//   rst_ni rises.
module hsl_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] hue_i,
  input  logic [15:0] saturation_i,
  input  logic [15:0] lightness_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);
  import hsl2rgb_pkg::*;

  logic                en;
  logic [NumStg-1:0]   vld_q, vld_d;
  shape_t              shape;
  chan_t [NumChan-1:0] chan;

  assign en      = !vld_q[NumStg-1] || ready_i;
  assign ready_o = en;
  assign valid_o = vld_q[NumStg-1];
  assign vld_d   = {vld_q[NumStg-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  hsl2rgb_prep u_prep (
    .clk_i        (clk_i),
    .en_i         (en),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .shape_o      (shape),
    .chan_o       (chan)
  );

  hsl2rgb_ramp u_ramp_r (
    .clk_i   (clk_i),
    .en_i    (en),
    .shape_i (shape),
    .chan_i  (chan[0]),
    .byte_o  (red_o)
  );

  hsl2rgb_ramp u_ramp_g (
    .clk_i   (clk_i),
    .en_i    (en),
    .shape_i (shape),
    .chan_i  (chan[1]),
    .byte_o  (green_o)
  );

  hsl2rgb_ramp u_ramp_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .shape_i (shape),
    .chan_i  (chan[2]),
    .byte_o  (blue_o)
  );

`ifndef SYNTH
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> vld_q[0])
    else $error("accepted word did not enter first stage");

  a_reaches_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[NumStg-2] |=> valid_o)
    else $error("word lost before output stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");
`endif

endmodule
